>>> design/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int TOTAL_CELLS = COLUMNS * ROWS;
    localparam int ADDR_W      = $clog2(TOTAL_CELLS);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int CELL_W      = 16;
    localparam int POS_W       = 11;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [ADDR_W:0]   pos_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [CELL_W-1:0] cell_t;

    localparam cell_t     BLANK_CELL   = 16'h0F20;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam addr_t LAST_CELL      = addr_t'(TOTAL_CELLS - 1);
    localparam addr_t LAST_ROW_START = addr_t'((ROWS - 1) * COLUMNS);
    localparam addr_t COPY_END       = addr_t'((ROWS - 1) * COLUMNS - 1);
    localparam addr_t ROW_STEP       = addr_t'(COLUMNS);
    localparam col_t  LAST_COL       = col_t'(COLUMNS - 1);

endpackage

>>> design/tcw_ram.sv
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/text_console_writer_core.sv
`timescale 1ns / 1ps

// Channel  | Ports                                          | Handshake
// ---------+------------------------------------------------+---------------------------
// command  | operation, character, attribute, cell_index    | taken when start && !busy
// result   | cursor_position, cell_value, scrolled          | one-cycle strobe on done
//
// A plain put, newline, backspace or unused code answers straight from idle; an in-range
// read goes through S_READ (registered RAM read), a read past the end answers from idle.
// A scroll copies each cell up a row through the single RAM port pair (S_COPY_RD, then
// S_COPY_WR), then blanks the last row in S_FILL. A clear sweeps every cell in S_FILL.
// After reset the block blanks the whole screen with busy high.
// The receiver cannot stall; done is high for one cycle only, the other results hold.

module text_console_writer_core
    import tcw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            operation,
    input  logic [7:0]            character,
    input  logic [7:0]            attribute,
    input  logic [10:0]           cell_index,
    output logic                  done,
    output logic [POS_W-1:0]      cursor_position,
    output logic [CELL_W-1:0]     cell_value,
    output logic                  scrolled
);

    localparam logic [2:0] S_INIT    = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_READ    = 3'd2;
    localparam logic [2:0] S_COPY_RD = 3'd3;
    localparam logic [2:0] S_COPY_WR = 3'd4;
    localparam logic [2:0] S_FILL    = 3'd5;

    logic [2:0] state_reg, state_next;
    addr_t      ptr_reg, ptr_next;
    addr_t      cursor_reg, cursor_next;
    col_t       col_reg, col_next;
    logic       done_reg, done_next;
    logic       scroll_flag_reg, scroll_flag_next;
    cell_t      value_reg, value_next;
    logic       scrolled_reg, scrolled_next;

    logic  accept;
    logic  in_range;
    pos_t  nl_pos;
    logic  ram_we;
    addr_t ram_waddr;
    cell_t ram_wdata;
    addr_t ram_raddr;
    cell_t ram_rdata;

    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(TOTAL_CELLS)
    ) u_screen (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign in_range = 32'(cell_index) < 32'(TOTAL_CELLS);
    assign nl_pos   = {1'b0, cursor_reg} - pos_t'(col_reg) + pos_t'(COLUMNS);

    always_comb
    begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        cursor_next      = cursor_reg;
        col_next         = col_reg;
        done_next        = 1'b0;
        scroll_flag_next = scroll_flag_reg;
        value_next       = value_reg;
        scrolled_next    = scrolled_reg;
        ram_we           = 1'b0;
        ram_waddr        = ptr_reg;
        ram_wdata        = BLANK_CELL;
        ram_raddr        = addr_t'(cell_index);

        case (state_reg)
            S_INIT:
            begin
                ram_we = 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    value_next    = '0;
                    scrolled_next = 1'b0;
                    done_next     = 1'b1;
                    case (operation)
                        OP_PUT:
                        begin
                            if (character == CH_NEWLINE)
                            begin
                                if (nl_pos >= pos_t'(TOTAL_CELLS))
                                begin
                                    done_next        = 1'b0;
                                    ptr_next         = '0;
                                    cursor_next      = LAST_ROW_START;
                                    col_next         = '0;
                                    scroll_flag_next = 1'b1;
                                    state_next       = S_COPY_RD;
                                end
                                else
                                begin
                                    cursor_next = nl_pos[ADDR_W-1:0];
                                    col_next    = '0;
                                end
                            end
                            else if (character == CH_BACKSPACE)
                            begin
                                if (cursor_reg != '0)
                                begin
                                    ram_we      = 1'b1;
                                    ram_waddr   = cursor_reg - 1'b1;
                                    ram_wdata   = {attribute, CH_SPACE};
                                    cursor_next = cursor_reg - 1'b1;
                                    col_next    = (col_reg == '0) ? LAST_COL
                                                                  : col_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cursor_reg;
                                ram_wdata = {attribute, character};
                                if (cursor_reg == LAST_CELL)
                                begin
                                    done_next        = 1'b0;
                                    ptr_next         = '0;
                                    cursor_next      = LAST_ROW_START;
                                    col_next         = '0;
                                    scroll_flag_next = 1'b1;
                                    state_next       = S_COPY_RD;
                                end
                                else
                                begin
                                    cursor_next = cursor_reg + 1'b1;
                                    col_next    = (col_reg == LAST_COL) ? '0
                                                                        : col_reg + 1'b1;
                                end
                            end
                        end

                        OP_CLEAR:
                        begin
                            done_next        = 1'b0;
                            ptr_next         = '0;
                            cursor_next      = '0;
                            col_next         = '0;
                            scroll_flag_next = 1'b0;
                            state_next       = S_FILL;
                        end

                        OP_READ:
                        begin
                            // out-of-range reads answer zero at once
                            if (in_range)
                            begin
                                done_next  = 1'b0;
                                state_next = S_READ;
                            end
                        end

                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                done_next     = 1'b1;
                value_next    = ram_rdata;
                scrolled_next = 1'b0;
                state_next    = S_IDLE;
            end

            S_COPY_RD:
            begin
                ram_raddr  = ptr_reg + ROW_STEP;
                state_next = S_COPY_WR;
            end

            S_COPY_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (ptr_reg == COPY_END)
                begin
                    ptr_next   = LAST_ROW_START;
                    state_next = S_FILL;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_COPY_RD;
                end
            end

            S_FILL:
            begin
                ram_we = 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    done_next     = 1'b1;
                    value_next    = '0;
                    scrolled_next = scroll_flag_reg;
                    state_next    = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            ptr_reg         <= '0;
            cursor_reg      <= '0;
            col_reg         <= '0;
            done_reg        <= 1'b0;
            scroll_flag_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ptr_reg         <= ptr_next;
            cursor_reg      <= cursor_next;
            col_reg         <= col_next;
            done_reg        <= done_next;
            scroll_flag_reg <= scroll_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        scrolled_reg <= scrolled_next;
    end

    assign done            = done_reg;
    assign cursor_position = POS_W'(cursor_reg);
    assign cell_value      = value_reg;
    assign scrolled        = scrolled_reg;

endmodule
